### design/asg_pkg.sv
// Shared types, constants and helpers of the arpeggio step generator.
package asg_pkg;

    localparam int KEY_LIMIT     = 108;
    localparam int MAX_TONES     = 8;
    localparam int MAX_SLOTS     = 64;
    localparam int MAX_OCTAVES   = 9;
    localparam int SEMIS_PER_OCT = 12;
    localparam int MAX_PERIOD    = 4096;
    localparam int MAX_NOTES     = 64;

    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // direction codes
    localparam logic [1:0] DIR_UP     = 2'd0;
    localparam logic [1:0] DIR_DOWN   = 2'd1;
    localparam logic [1:0] DIR_UPDOWN = 2'd2;
    localparam logic [1:0] DIR_RANDOM = 2'd3;

    // mode codes
    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_SORT = 2'd1;
    localparam logic [1:0] MODE_SYNC = 2'd2;

    // register indexes
    localparam logic [2:0] REG_INTERVALS = 3'd0;
    localparam logic [2:0] REG_TONES     = 3'd1;
    localparam logic [2:0] REG_OCTAVES   = 3'd2;
    localparam logic [2:0] REG_DIRECTION = 3'd3;
    localparam logic [2:0] REG_MODE      = 3'd4;
    localparam logic [2:0] REG_STEP      = 3'd5;
    localparam logic [2:0] REG_GATE      = 3'd6;
    localparam logic [2:0] REG_PERIOD    = 3'd7;

    // clamped configuration seen by front and back
    typedef struct packed {
        logic [39:0] intervals;
        logic [3:0]  tones;
        logic [6:0]  range;
        logic [1:0]  dir;
        logic [1:0]  mode;
        logic [19:0] step;
        logic [12:0] period;
    } t_cfg;

    // one period's worth of slot work, handed from front to back
    typedef struct packed {
        logic [20:0] off;
        logic [6:0]  mr;
        logic [12:0] mt;
        logic [6:0]  qt;
        logic [7:0]  mu;
        logic [12:0] total;
        logic [6:0]  base_key;
        logic [5:0]  nidx;
    } t_job;

    // octave number of a step index: idx / tones, idx below 9 * tones
    function automatic logic [3:0] oct_of(input logic [6:0] idx, input logic [3:0] tones);
        logic [3:0] oct;
        oct = 4'd0;
        for (int k = 1; k <= MAX_OCTAVES - 1; k++) begin
            if ({1'b0, idx} >= 8'(k) * {4'b0, tones}) begin
                oct = 4'(k);
            end
        end
        return oct;
    endfunction

endpackage

### design/asg_div.sv
// Restoring divider, one quotient bit per cycle.
module asg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quot,
    output logic [19:0] o_rem
);
    import asg_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] r_q;
    logic [20:0] r_r;
    logic [19:0] r_d;
    logic [20:0] trial;
    logic        fits;

    assign trial = {r_r[19:0], r_q[32]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[31:0], fits};
                r_r   <= fits ? trial - {1'b0, r_d} : trial;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[19:0];
endmodule

### design/asg_front.sv
// Front end: takes input transactions, works out first slot and start counters.
module asg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  asg_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_eligible,
    input  logic [6:0]    i_base_key,
    input  logic [31:0]   i_frames_played,
    input  logic [5:0]    i_note_index,
    input  logic [6:0]    i_note_count,
    output logic          o_push,
    output asg_pkg::t_job o_job,
    input  logic          i_full
);
    import asg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_F = 3'd1;
    localparam logic [2:0] S_DIV_T = 3'd2;
    localparam logic [2:0] S_DIV_R = 3'd3;
    localparam logic [2:0] S_DIV_U = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]  r_state;
    logic        r_go;
    logic [31:0] r_fp;
    logic [6:0]  r_key;
    logic [5:0]  r_nidx;
    logic [12:0] r_total;
    logic [32:0] r_s;
    logic [20:0] r_off;
    logic [12:0] r_mt;
    logic [6:0]  r_qt;
    logic [6:0]  r_mr;
    logic [7:0]  r_mu;

    logic [6:0]  nc;
    logic [12:0] n_total;
    logic [7:0]  ud;
    logic [32:0] dividend;
    logic [19:0] divisor;
    logic        div_done;
    logic [32:0] quot;
    logic [19:0] rem;

    assign nc = (i_note_count == 7'd0) ? 7'd1 :
                (i_note_count > 7'(MAX_NOTES)) ? 7'(MAX_NOTES) : i_note_count;
    assign n_total = 13'({6'b0, i_cfg.range} * {6'b0, nc});
    assign ud = {i_cfg.range, 1'b0} - 8'd2;

    always_comb begin
        case (r_state)
            S_DIV_F: begin
                dividend = {1'b0, r_fp} + {13'b0, i_cfg.step} - 33'd1;
                divisor  = i_cfg.step;
            end
            S_DIV_T: begin
                dividend = r_s;
                divisor  = {7'b0, r_total};
            end
            S_DIV_R: begin
                dividend = {20'b0, r_mt};
                divisor  = {13'b0, i_cfg.range};
            end
            S_DIV_U: begin
                dividend = r_s;
                divisor  = {12'b0, ud};
            end
            default: begin
                dividend = '0;
                divisor  = 20'd1;
            end
        endcase
    end

    asg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_eligible) begin
                        r_fp    <= i_frames_played;
                        r_key   <= i_base_key;
                        r_nidx  <= i_note_index;
                        r_total <= n_total;
                        r_state <= S_DIV_F;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_F: begin
                    if (div_done) begin
                        r_s     <= quot;
                        r_off   <= {1'b0, i_cfg.step} - {1'b0, rem};
                        r_state <= S_DIV_T;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_T: begin
                    if (div_done) begin
                        r_mt    <= rem[12:0];
                        r_state <= S_DIV_R;
                        r_go    <= 1'b1;
                    end
                end
                S_DIV_R: begin
                    if (div_done) begin
                        r_qt <= quot[6:0];
                        r_mr <= rem[6:0];
                        if (i_cfg.range < 7'd2) begin
                            r_mu    <= '0;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_DIV_U;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_DIV_U: begin
                    if (div_done) begin
                        r_mu    <= rem[7:0];
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_job   = '{off: r_off, mr: r_mr, mt: r_mt, qt: r_qt, mu: r_mu,
                       total: r_total, base_key: r_key, nidx: r_nidx};
endmodule

### design/asg_queue.sv
// Two-entry job queue between front and back.
module asg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output asg_pkg::t_job o_job,
    output logic          o_empty
);
    import asg_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];
endmodule

### design/asg_back.sv
// Back end: walks the slots of one job, picks step index and key.
module asg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  asg_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  asg_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [6:0]    o_note_key,
    output logic [12:0]   o_start_offset,
    output logic [6:0]    o_step_index,
    output logic          o_muted,
    output logic          o_last
);
    import asg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_IDX  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic [31:0] r_lfsr;
    logic [20:0] r_off;
    logic [6:0]  r_mr;
    logic [12:0] r_mt;
    logic [6:0]  r_qt;
    logic [7:0]  r_mu;
    logic [12:0] r_total;
    logic [6:0]  r_base;
    logic [5:0]  r_nidx;
    logic [5:0]  r_n;
    logic [6:0]  r_idx;
    logic        r_smute;
    logic        r_valid;

    logic [20:0] off_next;
    logic        last_slot;
    logic        sort_mute;
    logic [31:0] lfsr_adv;
    logic [38:0] prod;
    logic [7:0]  ud;
    logic [6:0]  idx_sel;
    logic [3:0]  oct;
    logic [6:0]  tone_pos;
    logic [4:0]  interval;
    logic [8:0]  key9;
    logic        key_mute;
    logic        out_load;
    logic        mr_wrap;
    logic        mt_wrap;

    assign off_next  = r_off + {1'b0, i_cfg.step};
    assign last_slot = (off_next > {8'b0, i_cfg.period}) || (r_n == 6'(MAX_SLOTS - 1));
    assign sort_mute = (i_cfg.mode == MODE_SORT) && (r_qt != {1'b0, r_nidx});
    assign lfsr_adv  = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);
    assign prod      = {32'b0, i_cfg.range} * {7'b0, lfsr_adv};
    assign ud        = {i_cfg.range, 1'b0} - 8'd2;

    always_comb begin
        case (i_cfg.dir)
            DIR_UP:     idx_sel = r_mr;
            DIR_DOWN:   idx_sel = i_cfg.range - 7'd1 - r_mr;
            DIR_UPDOWN: begin
                if (i_cfg.range < 7'd2) begin
                    idx_sel = '0;
                end else if (r_mu >= {1'b0, i_cfg.range}) begin
                    idx_sel = 7'(ud - r_mu);
                end else begin
                    idx_sel = r_mu[6:0];
                end
            end
            default:    idx_sel = prod[38:32];
        endcase
    end

    assign oct      = oct_of(r_idx, i_cfg.tones);
    assign tone_pos = r_idx - 7'({3'b0, oct} * i_cfg.tones);
    assign interval = i_cfg.intervals[tone_pos[2:0] * 5 +: 5];
    assign key9     = {2'b0, r_base} + 9'({5'b0, oct} * 9'(SEMIS_PER_OCT)) + {4'b0, interval};
    assign key_mute = key9 >= 9'(KEY_LIMIT);
    assign out_load = (r_state == S_OUT) && (!r_valid || !i_stall);
    assign mr_wrap  = (r_mr == i_cfg.range - 7'd1);
    assign mt_wrap  = (r_mt == r_total - 13'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lfsr  <= LFSR_SEED;
            r_valid <= 1'b0;
        end else begin
            // new slot loads, a stalled one holds, a taken one clears
            r_valid <= out_load || (r_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_off   <= i_job.off;
                        r_mr    <= i_job.mr;
                        r_mt    <= i_job.mt;
                        r_qt    <= i_job.qt;
                        r_mu    <= i_job.mu;
                        r_total <= i_job.total;
                        r_base  <= i_job.base_key;
                        r_nidx  <= i_job.nidx;
                        r_n     <= '0;
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    if (r_off > {8'b0, i_cfg.period}) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_smute <= sort_mute;
                        r_idx   <= sort_mute ? 7'd0 : idx_sel;
                        if (!sort_mute && i_cfg.dir == DIR_RANDOM) begin
                            r_lfsr <= lfsr_adv;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        o_muted        <= r_smute || key_mute;
                        o_note_key     <= (r_smute || key_mute) ? 7'd0 : key9[6:0];
                        o_step_index   <= r_idx;
                        o_start_offset <= r_off[12:0];
                        o_last         <= last_slot;
                        r_off          <= off_next;
                        r_n            <= r_n + 6'd1;
                        r_mr           <= mr_wrap ? 7'd0 : r_mr + 7'd1;
                        r_mt           <= mt_wrap ? 13'd0 : r_mt + 13'd1;
                        r_qt           <= mt_wrap ? 7'd0 : (mr_wrap ? r_qt + 7'd1 : r_qt);
                        r_mu           <= (i_cfg.range < 7'd2 || r_mu == ud - 8'd1) ? 8'd0
                                          : r_mu + 8'd1;
                        r_state        <= last_slot ? S_IDLE : S_IDX;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;

`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && last_slot) |=> (r_state == S_IDLE))
        else $error("slot walk did not end after last slot");
    a_mute_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_muted) |-> (o_note_key == 7'd0))
        else $error("muted slot with nonzero key");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_idx < i_cfg.range))
        else $error("step index out of range");
`endif
endmodule

### design/arpeggio_step_generator.sv
// Arpeggio step generator top level: config registers, front, queue, back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one transaction per audio
//   period of a held base note. An ineligible note is taken and gives nothing.
//   Output channel (o_out_valid / i_out_stall) gives one transaction per step
//   slot starting in the period, at most 64; o_last marks the final one.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx; write only idle.
// Operation:
//   The front runs four divisions (three when the step range is 1) in turn on
//   one shared serial divider, and takes no new item until its job is pushed.
//   The back handles each slot in two states (index, then key) and holds while
//   the output stalls; jobs wait between front and back in a two-deep job queue.
// Reset: synchronous, active low; registers return to their defaults and
//   the random LFSR to its seed. No clearing pass is needed.
// Stall: a stalled result holds in the output register; the back waits,
//   the queue fills, and then the front holds o_in_stall high.
module arpeggio_step_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_eligible,
    input  logic [6:0]  i_base_key,
    input  logic [31:0] i_frames_played,
    input  logic [5:0]  i_note_index,
    input  logic [6:0]  i_note_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_note_key,
    output logic [12:0] o_start_offset,
    output logic [6:0]  o_step_index,
    output logic        o_muted,
    output logic        o_last
);
    import asg_pkg::*;

    // configuration registers
    logic [39:0] r_intervals;
    logic [3:0]  r_tones;
    logic [3:0]  r_octaves;
    logic [1:0]  r_dir;
    logic [1:0]  r_mode;
    logic [19:0] r_step;
    logic [20:0] r_gate;   // held only; no effect on slots
    logic [12:0] r_period;

    t_cfg cfg;
    logic [3:0] tones_c;
    logic [3:0] oct_c;
    t_job job_in;
    t_job job_out;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intervals <= 40'd7296;
            r_tones     <= 4'd3;
            r_octaves   <= 4'd1;
            r_dir       <= DIR_UP;
            r_mode      <= MODE_FREE;
            r_step      <= 20'd4410;
            r_gate      <= 21'd4410;
            r_period    <= 13'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INTERVALS: r_intervals <= i_cfg_data;
                REG_TONES:     r_tones     <= i_cfg_data[3:0];
                REG_OCTAVES:   r_octaves   <= i_cfg_data[3:0];
                REG_DIRECTION: r_dir       <= i_cfg_data[1:0];
                REG_MODE:      r_mode      <= i_cfg_data[1:0];
                REG_STEP:      r_step      <= i_cfg_data[19:0];
                REG_GATE:      r_gate      <= i_cfg_data[20:0];
                REG_PERIOD:    r_period    <= i_cfg_data[12:0];
                default:       r_gate      <= r_gate;
            endcase
        end
    end

    // clamp to legal ranges; mode 3 acts as free, sync needs nothing special
    assign tones_c = (r_tones == 4'd0) ? 4'd1 :
                     (r_tones > 4'(MAX_TONES)) ? 4'(MAX_TONES) : r_tones;
    assign oct_c   = (r_octaves == 4'd0) ? 4'd1 :
                     (r_octaves > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : r_octaves;

    assign cfg.intervals = r_intervals;
    assign cfg.tones     = tones_c;
    assign cfg.range     = 7'(tones_c * oct_c);
    assign cfg.dir       = r_dir;
    assign cfg.mode      = (r_mode == MODE_SORT) ? MODE_SORT :
                           (r_mode == MODE_SYNC) ? MODE_SYNC : MODE_FREE;
    assign cfg.step      = (r_step == 20'd0) ? 20'd1 : r_step;
    assign cfg.period    = (r_period > 13'(MAX_PERIOD)) ? 13'(MAX_PERIOD) : r_period;

    asg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_eligible      (i_eligible),
        .i_base_key      (i_base_key),
        .i_frames_played (i_frames_played),
        .i_note_index    (i_note_index),
        .i_note_count    (i_note_count),
        .o_push          (push),
        .o_job           (job_in),
        .i_full          (full)
    );

    asg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    asg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_empty        (empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_note_key     (o_note_key),
        .o_start_offset (o_start_offset),
        .o_step_index   (o_step_index),
        .o_muted        (o_muted),
        .o_last         (o_last)
    );
endmodule
